### rtl/ssd_pkg.sv
// Shared types, sizes and tables for the multiplexed seven-segment driver.
// No dependencies; used by every module in rtl.
package ssd_pkg;

  localparam int NUM_ROWS   = 3;
  localparam int ROW_LEN    = 6;
  localparam int BUF_DEPTH  = NUM_ROWS * ROW_LEN;
  localparam int FONT_LEN   = 36;
  localparam int CODE_W     = 6;
  localparam int SEG_W      = 8;
  localparam int ROW_W      = 2;
  localparam int DOT_W      = 3;
  localparam int STEP_W     = 4;
  localparam int BUF_IDX_W  = $clog2(BUF_DEPTH);

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  typedef logic [SEG_W-1:0] seg_t;
  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
  } ssd_wr_t;

  function automatic seg_t glyph(input code_t code);
    seg_t g;
    case (code)
      6'd0:  g = 8'd63;
      6'd1:  g = 8'd6;
      6'd2:  g = 8'd91;
      6'd3:  g = 8'd79;
      6'd4:  g = 8'd102;
      6'd5:  g = 8'd109;
      6'd6:  g = 8'd125;
      6'd7:  g = 8'd7;
      6'd8:  g = 8'd127;
      6'd9:  g = 8'd111;
      6'd10: g = 8'd0;
      6'd11: g = 8'd64;
      6'd12: g = 8'd119;
      6'd13: g = 8'd124;
      6'd14: g = 8'd88;
      6'd15: g = 8'd94;
      6'd16: g = 8'd121;
      6'd17: g = 8'd113;
      6'd18: g = 8'd61;
      6'd19: g = 8'd116;
      6'd20: g = 8'd4;
      6'd21: g = 8'd30;
      6'd22: g = 8'd118;
      6'd23: g = 8'd56;
      6'd24: g = 8'd55;
      6'd25: g = 8'd40;
      6'd26: g = 8'd92;
      6'd27: g = 8'd115;
      6'd28: g = 8'd80;
      6'd29: g = 8'd109;
      6'd30: g = 8'd120;
      6'd31: g = 8'd62;
      6'd32: g = 8'd42;
      6'd33: g = 8'd118;
      6'd34: g = 8'd91;
      6'd35: g = 8'd255;
      default: g = 8'd0;
    endcase
    return g;
  endfunction

  function automatic logic [BUF_IDX_W-1:0] scan_map(input logic [STEP_W-1:0] step);
    logic [BUF_IDX_W-1:0] idx;
    case (step)
      4'd0:  idx = 5'd0;
      4'd1:  idx = 5'd1;
      4'd2:  idx = 5'd2;
      4'd3:  idx = 5'd3;
      4'd4:  idx = 5'd4;
      4'd5:  idx = 5'd5;
      4'd6:  idx = 5'd11;
      4'd7:  idx = 5'd10;
      4'd8:  idx = 5'd12;
      4'd9:  idx = 5'd13;
      4'd10: idx = 5'd14;
      4'd11: idx = 5'd15;
      4'd12: idx = 5'd6;
      4'd13: idx = 5'd7;
      4'd14: idx = 5'd8;
      4'd15: idx = 5'd9;
      default: idx = 5'd0;
    endcase
    return idx;
  endfunction

endpackage

### rtl/ssd_lane.sv
// One digit lane: font lookup for a character code and the optional decimal point.
// Depends on ssd_pkg.
module ssd_lane (
  input  ssd_pkg::code_t code,
  input  logic           dot_hit,
  output ssd_pkg::seg_t  pattern
);
  import ssd_pkg::*;

  seg_t g;

  assign g       = glyph(code);
  assign pattern = {g[SEG_W-1] ^ dot_hit, g[SEG_W-2:0]};

endmodule

### rtl/ssd_buffer.sv
// Segment buffer of three rows of six bytes: merges the lane patterns into one row
// and reads the byte for the current scan position. Depends on ssd_pkg.
module ssd_buffer (
  input  logic                          clk,
  input  logic                          rst,
  input  ssd_pkg::ssd_wr_t              wr,
  input  ssd_pkg::seg_t                 lane_pat [ssd_pkg::ROW_LEN],
  input  logic [ssd_pkg::BUF_IDX_W-1:0] rd_idx,
  output ssd_pkg::seg_t                 rd_data
);
  import ssd_pkg::*;

  seg_t buf_q [BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUF_DEPTH; i++) begin
        buf_q[i] <= '0;
      end
    end else if (wr.en) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        if (wr.row == ROW_W'(r)) begin
          for (int j = 0; j < ROW_LEN; j++) begin
            buf_q[r*ROW_LEN + j] <= lane_pat[j];
          end
        end
      end
    end
  end

  assign rd_data = buf_q[rd_idx];

endmodule

### rtl/seven_segment_mux_display_top.sv
// Multiplexed seven-segment display driver for 16 scanned digits.
// A tick word gives its result word on the cycle after acceptance. Throughput: one word
// per cycle when not stalled; a write word takes effect for a tick that follows it.
// Reset clears the segment buffer to blank and returns the scan to its first step.
// Depends on ssd_pkg, ssd_lane and ssd_buffer.
module seven_segment_mux_display_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        mode,
  input  logic [ssd_pkg::ROW_W-1:0]   row,
  input  ssd_pkg::code_t              char_a,
  input  ssd_pkg::code_t              char_b,
  input  ssd_pkg::code_t              char_c,
  input  ssd_pkg::code_t              char_d,
  input  ssd_pkg::code_t              char_e,
  input  ssd_pkg::code_t              char_f,
  input  logic [ssd_pkg::DOT_W-1:0]   dot_pos,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  cathode_low,
  output logic [7:0]                  cathode_high,
  output ssd_pkg::seg_t               segments
);
  import ssd_pkg::*;

  code_t            codes    [ROW_LEN];
  seg_t             lane_pat [ROW_LEN];
  ssd_wr_t          wr;
  logic             accept;
  logic             tick;
  logic [STEP_W-1:0] step;
  seg_t             rd_data;

  assign codes[0] = char_a;
  assign codes[1] = char_b;
  assign codes[2] = char_c;
  assign codes[3] = char_d;
  assign codes[4] = char_e;
  assign codes[5] = char_f;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign tick     = accept && (mode == MODE_TICK);

  assign wr.en  = accept && (mode == MODE_WRITE);
  assign wr.row = row;

  for (genvar j = 0; j < ROW_LEN; j++) begin : g_lane
    ssd_lane u_lane (
      .code    (codes[j]),
      .dot_hit (dot_pos == DOT_W'(j + 1)),
      .pattern (lane_pat[j])
    );
  end

  ssd_buffer u_buffer (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .lane_pat (lane_pat),
    .rd_idx   (scan_map(step)),
    .rd_data  (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (tick) begin
        step      <= step + 1'b1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      cathode_low  <= step[STEP_W-1] ? 8'd0 : (8'd1 << step[STEP_W-2:0]);
      cathode_high <= step[STEP_W-1] ? (8'd1 << step[STEP_W-2:0]) : 8'd0;
      segments     <= ~rd_data;
    end
  end

endmodule

### verif/tb_seven_segment_mux_display_top.sv
// Self-checking testbench for seven_segment_mux_display_top: directed font, dot and scan
// words, then random traffic under three idling patterns, each result checked in order.
// Depends on ssd_pkg and the RTL under rtl; reads no files.
module tb_seven_segment_mux_display_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int RANDOM_WORDS   = 650;

  localparam seg_t FONT_BYTES [FONT_LEN] = '{
    8'd63,  8'd6,   8'd91,  8'd79,  8'd102, 8'd109, 8'd125, 8'd7,   8'd127, 8'd111,
    8'd0,   8'd64,  8'd119, 8'd124, 8'd88,  8'd94,  8'd121, 8'd113, 8'd61,  8'd116,
    8'd4,   8'd30,  8'd118, 8'd56,  8'd55,  8'd40,  8'd92,  8'd115, 8'd80,  8'd109,
    8'd120, 8'd62,  8'd42,  8'd118, 8'd91,  8'd255
  };

  typedef struct packed {
    logic                mode;
    logic [ROW_W-1:0]    row;
    code_t [ROW_LEN-1:0] chars;
    logic [DOT_W-1:0]    dot;
  } disp_word_t;

  typedef struct packed {
    logic [7:0] cath_lo;
    logic [7:0] cath_hi;
    seg_t       seg;
  } scan_out_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic             mode;
  logic [ROW_W-1:0] row;
  code_t            char_a;
  code_t            char_b;
  code_t            char_c;
  code_t            char_d;
  code_t            char_e;
  code_t            char_f;
  logic [DOT_W-1:0] dot_pos;
  logic             out_valid;
  logic             out_ready;
  logic [7:0]       cathode_low;
  logic [7:0]       cathode_high;
  seg_t             segments;

  seg_t              shadow_buf [BUF_DEPTH];
  logic [STEP_W-1:0] shadow_step;
  scan_out_t         expected_scans [$];

  int send_idle_pct = 33;
  int recv_idle_pct = 80;
  int idle_cycles = 0;
  int n_ticks = 0;
  int n_writes = 0;
  int n_dropped_writes = 0;
  int n_results = 0;
  int n_errors = 0;

  seven_segment_mux_display_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .row          (row),
    .char_a       (char_a),
    .char_b       (char_b),
    .char_c       (char_c),
    .char_d       (char_d),
    .char_e       (char_e),
    .char_f       (char_f),
    .dot_pos      (dot_pos),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cathode_low  (cathode_low),
    .cathode_high (cathode_high),
    .segments     (segments)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int scan_slot(input logic [STEP_W-1:0] step);
    int s;
    s = step;
    if (s < ROW_LEN) return s;
    if (s < 8) return 2 * ROW_LEN - 1 - (s - ROW_LEN);
    if (s < 12) return 2 * ROW_LEN + (s - 8);
    return ROW_LEN + (s - 12);
  endfunction

  function automatic void update_display_model(input disp_word_t w);
    scan_out_t r;
    int        base;
    if (w.mode == MODE_TICK) begin
      r.cath_lo = (shadow_step < 8) ? 8'(1 << shadow_step) : 8'd0;
      r.cath_hi = (shadow_step >= 8) ? 8'(1 << (shadow_step - 4'd8)) : 8'd0;
      r.seg = 8'hFF - shadow_buf[scan_slot(shadow_step)];
      expected_scans.push_back(r);
      shadow_step = shadow_step + 1'b1;
      n_ticks++;
    end else if (w.row >= NUM_ROWS) begin
      n_dropped_writes++;
    end else begin
      base = w.row * ROW_LEN;
      for (int j = 0; j < ROW_LEN; j++) begin
        shadow_buf[base + j] = (w.chars[j] < FONT_LEN) ? FONT_BYTES[w.chars[j]] : 8'd0;
      end
      if (w.dot >= 1 && w.dot <= ROW_LEN) begin
        shadow_buf[base + w.dot - 1] = shadow_buf[base + w.dot - 1] + 8'd128;
      end
      n_writes++;
    end
  endfunction

  function automatic disp_word_t random_word();
    disp_word_t w;
    w.mode = ($urandom_range(99) < 50) ? MODE_TICK : MODE_WRITE;
    w.row = ($urandom_range(99) < 6) ? ROW_W'(3) : ROW_W'($urandom_range(NUM_ROWS - 1));
    for (int j = 0; j < ROW_LEN; j++) begin
      w.chars[j] = ($urandom_range(99) < 80) ? code_t'($urandom_range(FONT_LEN - 1))
                                             : code_t'($urandom_range(63, FONT_LEN));
    end
    w.dot = DOT_W'($urandom_range(7));
    return w;
  endfunction

  function automatic disp_word_t tick_word();
    disp_word_t w;
    w = random_word();
    w.mode = MODE_TICK;
    return w;
  endfunction

  function automatic disp_word_t write_word(input int r, input int c0, input int c1,
                                            input int c2, input int c3, input int c4,
                                            input int c5, input int d);
    disp_word_t w;
    w.mode = MODE_WRITE;
    w.row = ROW_W'(r);
    w.chars[0] = code_t'(c0);
    w.chars[1] = code_t'(c1);
    w.chars[2] = code_t'(c2);
    w.chars[3] = code_t'(c3);
    w.chars[4] = code_t'(c4);
    w.chars[5] = code_t'(c5);
    w.dot = DOT_W'(d);
    return w;
  endfunction

  task automatic send_word(input disp_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= w.mode;
    row <= w.row;
    char_a <= w.chars[0];
    char_b <= w.chars[1];
    char_c <= w.chars[2];
    char_d <= w.chars[3];
    char_e <= w.chars[4];
    char_f <= w.chars[5];
    dot_pos <= w.dot;
    do @(posedge clk); while (!in_ready);
    update_display_model(w);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic test_blank_after_reset();
    repeat (2) send_word(tick_word());
  endtask

  task automatic test_font_and_dots();
    send_word(write_word(0, 0, 1, 2, 3, 4, 5, 7));
    send_word(write_word(1, 30, 31, 32, 33, 34, 35, 6));
    send_word(write_word(2, 36, 63, 6, 7, 8, 9, 1));
    send_word(write_word(3, 10, 11, 12, 13, 14, 15, 0));
    repeat (14) send_word(tick_word());
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_word(random_word());
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    scan_out_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (expected_scans.size() == 0) begin
        n_errors++;
        $display("%0t: result word with none expected: cathode_low=%02h cathode_high=%02h segments=%02h",
                 $time, cathode_low, cathode_high, segments);
      end else begin
        want = expected_scans.pop_front();
        if (cathode_low !== want.cath_lo) begin
          n_errors++;
          $display("%0t: cathode_low expected %02h actual %02h", $time, want.cath_lo, cathode_low);
        end
        if (cathode_high !== want.cath_hi) begin
          n_errors++;
          $display("%0t: cathode_high expected %02h actual %02h", $time, want.cath_hi,
                   cathode_high);
        end
        if (segments !== want.seg) begin
          n_errors++;
          $display("%0t: segments expected %02h actual %02h", $time, want.seg, segments);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d results outstanding", $time,
               idle_cycles, expected_scans.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_WRITE;
    row = '0;
    char_a = '0;
    char_b = '0;
    char_c = '0;
    char_d = '0;
    char_e = '0;
    char_f = '0;
    dot_pos = '0;
    out_ready = 1'b0;
    shadow_step = '0;
    for (int i = 0; i < BUF_DEPTH; i++) shadow_buf[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_idling(33, 80);
    test_blank_after_reset();
    test_font_and_dots();
    test_random_traffic(RANDOM_WORDS);
    set_idling(80, 33);
    test_random_traffic(RANDOM_WORDS);
    set_idling(0, 0);
    test_random_traffic(RANDOM_WORDS);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_scans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d scan ticks and %0d row writes, plus %0d writes to the unused row.",
             n_ticks, n_writes, n_dropped_writes);
    $display("%0d result words compared, %0d field mismatches.", n_results, n_errors);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
